[sv/sorted_list_table_defines.svh]
// Assertion macros shared by the sorted list table.
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Condition and consequence in the same cycle.
`define SLT_ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("sorted list table check failed");
// Consequence in the cycle after the condition.
`define SLT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("sorted list table check failed");
`else
`define SLT_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define SLT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

[sv/slt_pkg.sv]
`default_nettype none

package slt_pkg;

	// Number of cells in the chain and the width of the entry count.
	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;

	// Operation codes of an input item.
	typedef enum logic [2:0] {
		OP_INSERT     = 3'd0,
		OP_REMOVE_MIN = 3'd1,
		OP_REMOVE_MAX = 3'd2,
		OP_REMOVE_VAL = 3'd3,
		OP_SEARCH     = 3'd4
	} op_t;

	// Status codes of a result.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Command broadcast to every cell.
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_POP_FRONT,
		CMD_REMOVE_VAL
	} cell_cmd_t;

	// Per-cell control: the broadcast command and where the cell sits in the list.
	typedef struct packed {
		cell_cmd_t cmd;
		logic      valid;
		logic      first_free;
	} cell_ctl_t;

endpackage

`default_nettype wire

[sv/sorted_list_table.sv]
// Channel   Direction  Handshake             Ports
// command   in         start high, busy low  operation, value
// result    out        done, one cycle       status, found, removed_value, count
//
// Every item is handled by the chain of cells at once: all cells compare the value
// together and each holds its entry, takes a neighbor's entry or loads the value.
// The result shows on the outputs with done in the cycle after the item is taken.
// busy stays low, so a new item may follow in every cycle.
// The asynchronous reset empties the list; stored entries are not cleared.
// The receiver cannot stall; done marks each result for exactly one cycle.
`default_nettype none
`include "sorted_list_table_defines.svh"

module sorted_list_table (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [2:0]          operation,
	input  wire logic signed [31:0]  value,
	output logic                     done,
	output logic [1:0]               status,
	output logic                     found,
	output logic signed [31:0]       removed_value,
	output logic [4:0]               count
);

	localparam int CAP = slt_pkg::CAPACITY;
	localparam int CW = slt_pkg::CNT_W;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [CAP-1:0]     valid_vec;
	logic [CAP-1:0]     free_vec;
	logic [CAP-1:0]     last_vec;
	logic [CAP-1:0]     gt_vec;
	logic [CAP-1:0]     eq_vec;
	logic signed [31:0] entry_arr [CAP];
	logic               empty;
	logic               full;
	logic               any_match;
	logic               accept;
	slt_pkg::op_t       op;
	slt_pkg::cell_cmd_t cmd;
	logic signed [31:0] largest;
	logic [1:0]         status_d;
	logic               found_d;
	logic signed [31:0] removed_d;
	logic [4:0]         count_ext;

	logic               done_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic signed [31:0] removed_q;
	logic [4:0]         count_out_q;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign op        = slt_pkg::op_t'(operation);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(CAP));
	assign any_match = |eq_vec;

	// Position of each cell relative to the fill level.
	always_comb begin
		for (int k = 0; k < CAP; k++) begin
			valid_vec[k] = (CW'(k) < count_q);
			free_vec[k]  = (CW'(k) == count_q);
			last_vec[k]  = (CW'(k + 1) == count_q);
		end
	end

	// The chain of cells, each linked to its two neighbors.
	for (genvar k = 0; k < CAP; k++) begin : g_cell
		slt_pkg::cell_ctl_t ctl;
		logic               l_gt;
		logic signed [31:0] l_entry;
		logic signed [31:0] r_entry;

		assign ctl.cmd        = cmd;
		assign ctl.valid      = valid_vec[k];
		assign ctl.first_free = free_vec[k];

		if (k == 0) begin : g_head
			assign l_gt    = 1'b0;
			assign l_entry = entry_arr[k];
		end else begin : g_body
			assign l_gt    = gt_vec[k-1];
			assign l_entry = entry_arr[k-1];
		end

		if (k == CAP - 1) begin : g_tail
			assign r_entry = entry_arr[k];
		end else begin : g_inner
			assign r_entry = entry_arr[k+1];
		end

		slt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.key         (value),
			.left_gt     (l_gt),
			.left_entry  (l_entry),
			.right_entry (r_entry),
			.entry       (entry_arr[k]),
			.gt          (gt_vec[k]),
			.eq          (eq_vec[k])
		);
	end

	// The largest entry sits in the last occupied cell.
	always_comb begin
		largest = '0;
		for (int k = 0; k < CAP; k++) begin
			largest = largest | (entry_arr[k] & {32{last_vec[k]}});
		end
	end

	// Decode the item into a cell command, the result and the next count.
	always_comb begin
		cmd       = slt_pkg::CMD_NONE;
		status_d  = slt_pkg::ST_OK;
		found_d   = 1'b0;
		removed_d = '0;
		count_d   = count_q;
		unique case (op)
			slt_pkg::OP_INSERT: begin
				if (full) begin
					status_d = slt_pkg::ST_FULL;
				end else begin
					cmd     = slt_pkg::CMD_INSERT;
					count_d = count_q + CW'(1);
				end
			end
			slt_pkg::OP_REMOVE_MIN: begin
				if (empty) begin
					status_d = slt_pkg::ST_EMPTY;
				end else begin
					cmd       = slt_pkg::CMD_POP_FRONT;
					removed_d = entry_arr[0];
					count_d   = count_q - CW'(1);
				end
			end
			slt_pkg::OP_REMOVE_MAX: begin
				if (empty) begin
					status_d = slt_pkg::ST_EMPTY;
				end else begin
					removed_d = largest;
					count_d   = count_q - CW'(1);
				end
			end
			slt_pkg::OP_REMOVE_VAL: begin
				if (empty) begin
					status_d = slt_pkg::ST_EMPTY;
				end else if (any_match) begin
					cmd       = slt_pkg::CMD_REMOVE_VAL;
					found_d   = 1'b1;
					removed_d = value;
					count_d   = count_q - CW'(1);
				end else begin
					status_d = slt_pkg::ST_NOTFOUND;
				end
			end
			slt_pkg::OP_SEARCH: begin
				if (empty) begin
					status_d = slt_pkg::ST_EMPTY;
				end else if (any_match) begin
					found_d = 1'b1;
				end else begin
					status_d = slt_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				cmd = slt_pkg::CMD_NONE;
			end
		endcase
		if (!accept) begin
			cmd     = slt_pkg::CMD_NONE;
			count_d = count_q;
		end
	end

	assign count_ext = 5'(count_d);

	// Control state: fill level and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			found_q     <= found_d;
			removed_q   <= removed_d;
			count_out_q <= count_ext;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found         = found_q;
	assign removed_value = removed_q;
	assign count         = count_out_q;

	// The fill level never passes the number of cells.
	`SLT_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAP))
	// An insert into a list with room grows it by one and reports success.
	`SLT_ASSERT_NEXT(a_insert_grows, clk, arst_n, accept && op == slt_pkg::OP_INSERT && !full, done && status == slt_pkg::ST_OK && count_q == $past(count_q) + CW'(1))
	// A match is only ever reported with a good status.
	`SLT_ASSERT_SAME(a_found_ok, clk, arst_n, done && found, status == slt_pkg::ST_OK)
	// A removed value other than zero only comes with a good status.
	`SLT_ASSERT_SAME(a_removed_ok, clk, arst_n, done && removed_value != 0, status == slt_pkg::ST_OK)

endmodule

`default_nettype wire

[sv/slt_cell.sv]
`default_nettype none

module slt_cell (
	input  wire logic                       clk,
	input  wire slt_pkg::cell_ctl_t         ctl,
	input  wire logic signed [slt_pkg::DATA_W-1:0] key,
	input  wire logic                       left_gt,
	input  wire logic signed [slt_pkg::DATA_W-1:0] left_entry,
	input  wire logic signed [slt_pkg::DATA_W-1:0] right_entry,
	output logic signed [slt_pkg::DATA_W-1:0]      entry,
	output logic                            gt,
	output logic                            eq
);

	logic signed [slt_pkg::DATA_W-1:0] entry_q;
	logic signed [slt_pkg::DATA_W-1:0] entry_d;
	logic                              ge;

	// Compare the key against the stored entry; an empty cell never matches.
	assign gt    = ctl.valid && (key < entry_q);
	assign eq    = ctl.valid && (key == entry_q);
	assign ge    = ctl.valid && !(entry_q < key);
	assign entry = entry_q;

	// Pick the next entry: hold, take a neighbor, or load the key.
	always_comb begin
		entry_d = entry_q;
		unique case (ctl.cmd)
			slt_pkg::CMD_INSERT: begin
				if (left_gt) begin
					entry_d = left_entry;
				end else if (gt || ctl.first_free) begin
					entry_d = key;
				end
			end
			slt_pkg::CMD_POP_FRONT: begin
				entry_d = right_entry;
			end
			slt_pkg::CMD_REMOVE_VAL: begin
				if (ge) begin
					entry_d = right_entry;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// The stored entry is payload and needs no reset.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire
